@@ src/pps_pkg.sv @@
// ----------------------------------------------------------------------------
// Preemptive priority scheduler package
// Operation and status codes shared by the scheduler sources.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pps_pkg;

    typedef logic [1:0] t_status;

    localparam logic    OP_ARRIVE = 1'b0;
    localparam logic    OP_TICK   = 1'b1;

    localparam t_status ST_OK     = 2'd0;
    localparam t_status ST_FULL   = 2'd1;
    localparam t_status ST_ZERO   = 2'd2;

endpackage

`default_nettype wire

@@ src/pps_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pps_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output      logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ src/preemptive_priority_scheduler.sv @@
// ----------------------------------------------------------------------------
// Preemptive priority scheduler
// Ready table of waiting tasks plus one running task, scheduled per tick.
// ----------------------------------------------------------------------------
// Input channel (i_valid / o_ready): an arrive item adds a task to the tail
// of the ready table; a tick item selects the highest-priority ready task
// (oldest wins ties), starts or preempts, and runs the current task one unit.
// Output channel (o_valid / i_ready): exactly one result item per input item.
// The ready table lives in a RAM kept in age order; one read port scans it
// and closes the gap when an entry is removed.
// Steps: an arrive goes straight to its result. A tick with waiting tasks
// reads every entry of the table to scan it, then decides; when the selected
// task leaves the table, the newer entries are moved down to close its gap.
// A tick with an empty table goes straight to its result. The RAM read port
// paces the scan and the compaction.
// o_ready is high only while the block is idle. A finished result waits in
// the output register while the receiver stalls; the next item is accepted,
// but its result waits until the register is free.
// Reset empties the table and clears the running task; no clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module preemptive_priority_scheduler #(
    parameter int READY_DEPTH   = 16,
    parameter int ID_BITS       = 8,
    parameter int PRIORITY_BITS = 8,
    parameter int DURATION_BITS = 16
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_valid,
    output      logic                               o_ready,
    input  wire logic                               i_operation,
    input  wire logic [ID_BITS-1:0]                 i_task_id,
    input  wire logic [PRIORITY_BITS-1:0]           i_task_priority,
    input  wire logic [DURATION_BITS-1:0]           i_task_duration,
    output      logic                               o_valid,
    input  wire logic                               i_ready,
    output      logic [1:0]                         o_status,
    output      logic                               o_ran,
    output      logic [ID_BITS-1:0]                 o_running_id,
    output      logic                               o_preempted,
    output      logic                               o_finished,
    output      logic [DURATION_BITS-1:0]           o_time_left,
    output      logic [$clog2(READY_DEPTH+1)-1:0]   o_ready_count
);

    localparam int AW = $clog2(READY_DEPTH);
    localparam int CW = $clog2(READY_DEPTH + 1);
    localparam int DW = ID_BITS + PRIORITY_BITS + DURATION_BITS;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SCAN   = 3'd1;
    localparam logic [2:0] S_DECIDE = 3'd2;
    localparam logic [2:0] S_SHIFT  = 3'd3;
    localparam logic [2:0] S_OUT    = 3'd4;

    logic [2:0]               r_state;
    logic [CW-1:0]            r_count;
    logic [CW-1:0]            r_ptr;
    logic                     r_cmp_en;
    logic [CW-1:0]            r_cmp_pos;
    logic                     r_is_tick;
    logic                     r_pre;
    pps_pkg::t_status         r_status;

    logic [ID_BITS-1:0]       r_best_id;
    logic [PRIORITY_BITS-1:0] r_best_pri;
    logic [DURATION_BITS-1:0] r_best_rem;
    logic [CW-1:0]            r_best_pos;

    logic                     r_cur_valid;
    logic [ID_BITS-1:0]       r_cur_id;
    logic [PRIORITY_BITS-1:0] r_cur_pri;
    logic [DURATION_BITS-1:0] r_cur_rem;

    logic [ID_BITS-1:0]       r_old_id;
    logic [PRIORITY_BITS-1:0] r_old_pri;
    logic [DURATION_BITS-1:0] r_old_rem;

    logic                     r_o_valid;
    pps_pkg::t_status         r_o_status;
    logic                     r_o_ran;
    logic [ID_BITS-1:0]       r_o_id;
    logic                     r_o_pre;
    logic                     r_o_fin;
    logic [DURATION_BITS-1:0] r_o_left;
    logic [CW-1:0]            r_o_count;

    logic                     w_accept;
    logic                     w_issue;
    logic                     w_out_free;
    logic                     w_ran;
    pps_pkg::t_status         n_status;
    logic [DURATION_BITS-1:0] n_rem;
    logic [CW-1:0]            w_prev_pos;
    logic [CW-1:0]            w_last_pos;

    logic                     ram_we;
    logic [AW-1:0]            ram_waddr;
    logic [DW-1:0]            ram_wdata;
    logic [DW-1:0]            ram_rdata;
    logic [ID_BITS-1:0]       rd_id;
    logic [PRIORITY_BITS-1:0] rd_pri;
    logic [DURATION_BITS-1:0] rd_rem;

    pps_ram #(
        .WIDTH (DW),
        .DEPTH (READY_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_ptr[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    assign {rd_id, rd_pri, rd_rem} = ram_rdata;

    assign o_ready    = (r_state == S_IDLE);
    assign w_accept   = i_valid && o_ready;
    assign w_issue    = (r_state inside {S_SCAN, S_SHIFT}) && (r_ptr != r_count);
    assign w_out_free = !r_o_valid || i_ready;
    assign w_prev_pos = r_cmp_pos - CW'(1);
    assign w_last_pos = r_count - CW'(1);
    assign w_ran      = r_is_tick && r_cur_valid;
    assign n_rem      = (r_cur_rem == '0) ? '0 : r_cur_rem - DURATION_BITS'(1);

    always_comb begin
        if (i_task_duration == '0) begin
            n_status = pps_pkg::ST_ZERO;
        end else if (r_count >= CW'(READY_DEPTH)) begin
            n_status = pps_pkg::ST_FULL;
        end else begin
            n_status = pps_pkg::ST_OK;
        end
    end

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_count[AW-1:0];
        ram_wdata = {i_task_id, i_task_priority, i_task_duration};
        case (r_state)
            S_IDLE: begin
                ram_we = w_accept && (i_operation == pps_pkg::OP_ARRIVE)
                         && (n_status == pps_pkg::ST_OK);
            end
            S_SHIFT: begin
                if (r_cmp_en) begin
                    ram_we    = 1'b1;
                    ram_waddr = w_prev_pos[AW-1:0];
                    ram_wdata = ram_rdata;
                end else if ((r_ptr == r_count) && r_pre) begin
                    ram_we    = 1'b1;
                    ram_waddr = w_last_pos[AW-1:0];
                    ram_wdata = {r_old_id, r_old_pri, r_old_rem};
                end
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_cmp_en    <= 1'b0;
            r_cur_valid <= 1'b0;
            r_o_valid   <= 1'b0;
        end else begin
            r_cmp_en  <= w_issue;
            r_cmp_pos <= r_ptr;
            if (w_issue) begin
                r_ptr <= r_ptr + CW'(1);
            end
            if (i_ready && (r_state != S_OUT)) begin
                r_o_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_pre     <= 1'b0;
                        r_ptr     <= '0;
                        r_is_tick <= (i_operation == pps_pkg::OP_TICK);
                        if (i_operation == pps_pkg::OP_ARRIVE) begin
                            r_status <= n_status;
                            if (n_status == pps_pkg::ST_OK) begin
                                r_count <= r_count + CW'(1);
                            end
                            r_state <= S_OUT;
                        end else begin
                            r_status <= pps_pkg::ST_OK;
                            r_state  <= (r_count != '0) ? S_SCAN : S_OUT;
                        end
                    end
                end
                S_SCAN: begin
                    if (r_cmp_en) begin
                        if ((r_cmp_pos == '0) || (rd_pri > r_best_pri)) begin
                            r_best_id  <= rd_id;
                            r_best_pri <= rd_pri;
                            r_best_rem <= rd_rem;
                            r_best_pos <= r_cmp_pos;
                        end
                        if (r_cmp_pos == w_last_pos) begin
                            r_state <= S_DECIDE;
                        end
                    end
                end
                S_DECIDE: begin
                    r_ptr <= r_best_pos + CW'(1);
                    if (!r_cur_valid) begin
                        r_cur_valid <= 1'b1;
                        r_cur_id    <= r_best_id;
                        r_cur_pri   <= r_best_pri;
                        r_cur_rem   <= r_best_rem;
                        r_state     <= S_SHIFT;
                    end else if (r_best_pri > r_cur_pri) begin
                        r_old_id  <= r_cur_id;
                        r_old_pri <= r_cur_pri;
                        r_old_rem <= r_cur_rem;
                        r_cur_id  <= r_best_id;
                        r_cur_pri <= r_best_pri;
                        r_cur_rem <= r_best_rem;
                        r_pre     <= 1'b1;
                        r_state   <= S_SHIFT;
                    end else begin
                        r_state <= S_OUT;
                    end
                end
                S_SHIFT: begin
                    if ((r_ptr == r_count) && !r_cmp_en) begin
                        if (!r_pre) begin
                            r_count <= w_last_pos;
                        end
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (w_out_free) begin
                        r_o_valid  <= 1'b1;
                        r_o_status <= r_status;
                        r_o_ran    <= w_ran;
                        r_o_id     <= w_ran ? r_cur_id : '0;
                        r_o_pre    <= r_pre;
                        r_o_fin    <= w_ran && (n_rem == '0);
                        r_o_left   <= w_ran ? n_rem : '0;
                        r_o_count  <= r_count;
                        if (w_ran) begin
                            r_cur_rem <= n_rem;
                            if (n_rem == '0) begin
                                r_cur_valid <= 1'b0;
                            end
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid       = r_o_valid;
    assign o_status      = r_o_status;
    assign o_ran         = r_o_ran;
    assign o_running_id  = r_o_id;
    assign o_preempted   = r_o_pre;
    assign o_finished    = r_o_fin;
    assign o_time_left   = r_o_left;
    assign o_ready_count = r_o_count;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(READY_DEPTH))
        else $error("ready table count exceeds depth");

    a_zero_dur_no_store: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_operation == pps_pkg::OP_ARRIVE) && (i_task_duration == '0))
        |=> $stable(r_count))
        else $error("zero-duration task was stored");

    a_idle_result_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_ran) |-> (!o_finished && !o_preempted && (o_time_left == '0)))
        else $error("result without a run carries run fields");

    a_reject_no_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status != pps_pkg::ST_OK)) |-> !o_ran)
        else $error("rejected arrive reports a run");

    a_preempt_keeps_running: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SHIFT && r_pre) |-> r_cur_valid)
        else $error("preemption without a running task");
`endif

endmodule

`default_nettype wire

@@ verif/tb_preemptive_priority_scheduler.sv @@
// ----------------------------------------------------------------------------
// Preemptive priority scheduler testbench
// Drives arrive and tick items through the valid/ready input channel. A
// scoreboard keeps its own copy of the ready table and the running task, and
// compares every result item, field by field, in order. A short directed
// table covers the empty tick, the zero-duration and table-full rejections,
// equal-priority hold, preemption and a full table. A long random part
// follows. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_preemptive_priority_scheduler;

    localparam int DEPTH        = 16;
    localparam int RANDOM_ITEMS = 1200;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int SETTLE       = 60;

    typedef struct packed {
        logic        op;
        logic [7:0]  id;
        logic [7:0]  pri;
        logic [15:0] dur;
    } t_sched_cmd;

    typedef struct packed {
        pps_pkg::t_status status;
        logic             ran;
        logic [7:0]       run_id;
        logic             preempted;
        logic             finished;
        logic [15:0]      left;
        logic [4:0]       count;
    } t_sched_result;

    typedef struct packed {
        t_sched_cmd    cmd;
        logic          fixed;
        t_sched_result want;
    } t_plan_row;

    logic        i_clk           = 1'b0;
    logic        i_rst_n         = 1'b0;
    logic        i_valid         = 1'b0;
    logic        i_operation     = 1'b0;
    logic [7:0]  i_task_id       = '0;
    logic [7:0]  i_task_priority = '0;
    logic [15:0] i_task_duration = '0;
    logic        i_ready         = 1'b0;
    logic        o_ready;
    logic        o_valid;
    logic [1:0]  o_status;
    logic        o_ran;
    logic [7:0]  o_running_id;
    logic        o_preempted;
    logic        o_finished;
    logic [15:0] o_time_left;
    logic [4:0]  o_ready_count;

    // scoreboard copy of the ready table and the running task
    logic        wait_valid [DEPTH];
    logic [7:0]  wait_id    [DEPTH];
    logic [7:0]  wait_pri   [DEPTH];
    logic [15:0] wait_rem   [DEPTH];
    int unsigned wait_age   [DEPTH];
    int unsigned wait_count;
    logic        run_busy;
    logic [7:0]  run_id;
    logic [7:0]  run_pri;
    logic [15:0] run_rem;

    t_sched_result report_q[$];
    t_plan_row     plan[$];
    int            items_sent   = 0;
    int            results_seen = 0;
    int            faults       = 0;
    int            cycles       = 0;

    preemptive_priority_scheduler DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_operation    (i_operation),
        .i_task_id      (i_task_id),
        .i_task_priority(i_task_priority),
        .i_task_duration(i_task_duration),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_status       (o_status),
        .o_ran          (o_ran),
        .o_running_id   (o_running_id),
        .o_preempted    (o_preempted),
        .o_finished     (o_finished),
        .o_time_left    (o_time_left),
        .o_ready_count  (o_ready_count)
    );

    always #4 i_clk = ~i_clk;

    function automatic void enqueue_task(logic [7:0] id, logic [7:0] pri,
                                         logic [15:0] rem);
        for (int i = 0; i < DEPTH; i++) begin
            if (!wait_valid[i]) begin
                wait_valid[i] = 1'b1;
                wait_id[i]    = id;
                wait_pri[i]   = pri;
                wait_rem[i]   = rem;
                wait_age[i]   = wait_count;
                wait_count++;
                return;
            end
        end
    endfunction

    function automatic t_sched_result run_scheduler(t_sched_cmd c);
        t_sched_result r;
        int            pick;
        int unsigned   gone;
        logic [7:0]    old_id;
        logic [7:0]    old_pri;
        logic [15:0]   old_rem;
        r = '0;
        if (c.op == pps_pkg::OP_ARRIVE) begin
            if (c.dur == 16'd0)
                r.status = pps_pkg::ST_ZERO;
            else if (wait_count >= DEPTH)
                r.status = pps_pkg::ST_FULL;
            else
                enqueue_task(c.id, c.pri, c.dur);
        end else begin
            pick = -1;
            for (int i = 0; i < DEPTH; i++) begin
                if (wait_valid[i] && (pick < 0 || wait_pri[i] > wait_pri[pick] ||
                    (wait_pri[i] == wait_pri[pick] && wait_age[i] < wait_age[pick])))
                    pick = i;
            end
            if (pick >= 0 && (!run_busy || wait_pri[pick] > run_pri)) begin
                old_id      = run_id;
                old_pri     = run_pri;
                old_rem     = run_rem;
                r.preempted = run_busy;
                run_busy    = 1'b1;
                run_id      = wait_id[pick];
                run_pri     = wait_pri[pick];
                run_rem     = wait_rem[pick];
                gone        = wait_age[pick];
                wait_valid[pick] = 1'b0;
                for (int i = 0; i < DEPTH; i++)
                    if (wait_valid[i] && wait_age[i] > gone)
                        wait_age[i]--;
                if (wait_count > 0)
                    wait_count--;
                if (r.preempted)
                    enqueue_task(old_id, old_pri, old_rem);
            end
            if (run_busy) begin
                if (run_rem != 16'd0)
                    run_rem--;
                r.ran    = 1'b1;
                r.run_id = run_id;
                r.left   = run_rem;
                if (run_rem == 16'd0) begin
                    r.finished = 1'b1;
                    run_busy   = 1'b0;
                end
            end
        end
        r.count = wait_count[4:0];
        return r;
    endfunction

    function automatic string describe(t_sched_result r);
        return $sformatf("status=%0d ran=%0d id=%0d pre=%0d fin=%0d left=%0d count=%0d",
                         r.status, r.ran, r.run_id, r.preempted, r.finished,
                         r.left, r.count);
    endfunction

    function automatic void add_row(logic op, logic [7:0] id, logic [7:0] pri,
                                    logic [15:0] dur, logic fixed,
                                    pps_pkg::t_status st, logic [4:0] cnt);
        t_plan_row row;
        row              = '0;
        row.cmd.op       = op;
        row.cmd.id       = id;
        row.cmd.pri      = pri;
        row.cmd.dur      = dur;
        row.fixed        = fixed;
        row.want.status  = st;
        row.want.count   = cnt;
        plan.insert(plan.size(), row);
    endfunction

    task automatic drive_item(t_sched_cmd cmd, logic fixed, t_sched_result want);
        t_sched_result predicted;
        int            gap;
        gap = ((items_sent / 50) % 3 != 0) ? $urandom_range(0, 11) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid         <= 1'b1;
        i_operation     <= cmd.op;
        i_task_id       <= cmd.id;
        i_task_priority <= cmd.pri;
        i_task_duration <= cmd.dur;
        do @(posedge i_clk); while (!o_ready);
        predicted = run_scheduler(cmd);
        report_q.insert(report_q.size(), fixed ? want : predicted);
        items_sent++;
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (report_q.size() != 0) @(posedge i_clk);
    endtask

    // result channel: stall at random, check each item in order
    initial begin
        int            stall;
        t_sched_result got;
        t_sched_result want;
        @(posedge i_rst_n);
        forever begin
            stall = ((results_seen / 40) % 3 != 0) ? $urandom_range(0, 11) : 0;
            @(negedge i_clk);
            if (stall > 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!o_valid);
            got = '{o_status, o_ran, o_running_id, o_preempted, o_finished,
                    o_time_left, o_ready_count};
            results_seen++;
            if (report_q.size() == 0) begin
                faults++;
                if (faults <= 10)
                    $display("unexpected result %0d: %s", results_seen, describe(got));
            end else begin
                want = report_q.pop_front();
                if (got.status !== want.status || got.ran !== want.ran ||
                    got.run_id !== want.run_id || got.preempted !== want.preempted ||
                    got.finished !== want.finished || got.left !== want.left ||
                    got.count !== want.count) begin
                    faults++;
                    if (faults <= 10)
                        $display("mismatch on result %0d: expected %s, got %s",
                                 results_seen, describe(want), describe(got));
                end
            end
        end
    end

    initial begin
        while (cycles < CYCLE_LIMIT) @(posedge i_clk) cycles++;
        $display("status: fail");
        $finish;
    end

    initial begin
        t_sched_cmd cmd;
        int         arrive_pct;
        int         roll;
        for (int i = 0; i < DEPTH; i++) begin
            wait_valid[i] = 1'b0;
            wait_age[i]   = 0;
        end
        wait_count = 0;
        run_busy   = 1'b0;
        run_id     = '0;
        run_pri    = '0;
        run_rem    = '0;
        arrive_pct = 50;

        add_row(pps_pkg::OP_TICK,   8'd0,   8'd0,   16'd0,    1'b1, pps_pkg::ST_OK,   5'd0);
        add_row(pps_pkg::OP_ARRIVE, 8'hA5,  8'h5A,  16'd0,    1'b1, pps_pkg::ST_ZERO, 5'd0);
        add_row(pps_pkg::OP_ARRIVE, 8'd255, 8'd128, 16'hFFFF, 1'b1, pps_pkg::ST_OK,   5'd1);
        add_row(pps_pkg::OP_TICK,   8'd0,   8'd0,   16'd0,    1'b0, pps_pkg::ST_OK,   5'd0);
        add_row(pps_pkg::OP_ARRIVE, 8'd7,   8'd128, 16'd2,    1'b0, pps_pkg::ST_OK,   5'd0);
        add_row(pps_pkg::OP_TICK,   8'hFF,  8'hFF,  16'hFFFF, 1'b0, pps_pkg::ST_OK,   5'd0);
        add_row(pps_pkg::OP_ARRIVE, 8'd9,   8'd255, 16'd1,    1'b0, pps_pkg::ST_OK,   5'd0);
        add_row(pps_pkg::OP_TICK,   8'd0,   8'd0,   16'd0,    1'b0, pps_pkg::ST_OK,   5'd0);
        for (int i = 0; i < 14; i++)
            add_row(pps_pkg::OP_ARRIVE, 8'(i * 18), 8'(i * 19), 16'(i + 1), 1'b0,
                    pps_pkg::ST_OK, 5'd0);
        add_row(pps_pkg::OP_ARRIVE, 8'd200, 8'd255, 16'd3,    1'b1, pps_pkg::ST_FULL, 5'd16);
        add_row(pps_pkg::OP_TICK,   8'd0,   8'd0,   16'd0,    1'b0, pps_pkg::ST_OK,   5'd0);
        add_row(pps_pkg::OP_TICK,   8'd0,   8'd0,   16'd0,    1'b0, pps_pkg::ST_OK,   5'd0);

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (plan[k])
            drive_item(plan[k].cmd, plan[k].fixed, plan[k].want);
        wait_drained();

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 100 == 0)
                arrive_pct = $urandom_range(25, 80);
            if (n == RANDOM_ITEMS / 2)
                wait_drained();
            cmd.op = ($urandom_range(0, 99) < arrive_pct) ? pps_pkg::OP_ARRIVE
                                                          : pps_pkg::OP_TICK;
            cmd.id = 8'($urandom);
            case ($urandom_range(0, 3))
                0: cmd.pri = 8'($urandom);
                1: cmd.pri = 8'($urandom_range(0, 3));
                2: cmd.pri = 8'($urandom_range(252, 255));
                default: cmd.pri = 8'($urandom_range(100, 140));
            endcase
            roll = $urandom_range(0, 99);
            if (roll < 3)
                cmd.dur = 16'd0;
            else if (roll < 7)
                cmd.dur = 16'($urandom);
            else
                cmd.dur = 16'($urandom_range(1, 8));
            drive_item(cmd, 1'b0, '0);
        end

        wait_drained();
        repeat (SETTLE) @(posedge i_clk);
        if (faults == 0 && report_q.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
